// ----- rtl/stack_with_middle_access_top_assert.svh -----
// ----------------------------------------------------------------------------
// stack_with_middle_access_top_assert.svh
// assertion macros for the stack with middle access block
// ----------------------------------------------------------------------------
`ifndef STACK_WITH_MIDDLE_ACCESS_TOP_ASSERT_SVH
`define STACK_WITH_MIDDLE_ACCESS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define SWMA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define SWMA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swma_pkg.sv -----
// ----------------------------------------------------------------------------
// swma_pkg
// shared types and constants of the stack with middle access block
// ----------------------------------------------------------------------------
package swma_pkg;

    // default number of stored words
    localparam int DEPTH_DEFAULT = 16;

    // payload widths
    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int DNOW_W  = 5;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_MID  = 2'd2,
        OP_DEL  = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // read address select
    typedef enum logic [1:0] {
        RD_TOP = 2'd0,
        RD_MID = 2'd1,
        RD_PTR = 2'd2
    } rd_sel_t;

    // result value select
    typedef enum logic [1:0] {
        VAL_ZERO  = 2'd0,
        VAL_RDATA = 2'd1,
        VAL_KEEP  = 2'd2
    } val_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic     wr_push;
        logic     wr_shift;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     cnt_dec;
        logic     ptr_load;
        logic     ptr_inc;
        logic     val_cap;
        logic     out_load;
        status_t  out_status;
        val_sel_t val_sel;
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic ptr_done;
        logic out_busy;
    } stat_t;

endpackage

// ----- rtl/swma_dp.sv -----
// ----------------------------------------------------------------------------
// swma_dp
// element memory, count and shift pointer, result register
// ----------------------------------------------------------------------------
module swma_dp #(
    parameter int DEPTH = swma_pkg::DEPTH_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swma_pkg::cmd_t                   cmd,
    output swma_pkg::stat_t                  stat,
    input  logic signed [swma_pkg::WORD_W-1:0] push_value,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [swma_pkg::WORD_W-1:0] result_value,
    output swma_pkg::status_t                status,
    output logic [swma_pkg::DNOW_W-1:0]      depth_now
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] top_idx, mid_idx, shift_idx, rd_idx;
    logic [swma_pkg::WORD_W-1:0] mem [DEPTH];
    logic [swma_pkg::WORD_W-1:0] rdata_reg;
    logic [swma_pkg::WORD_W-1:0] wr_data;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic          out_valid_reg, out_valid_next;
    logic signed [swma_pkg::WORD_W-1:0] value_reg, value_next;
    swma_pkg::status_t status_reg;
    logic [swma_pkg::DNOW_W-1:0] depth_reg;

    // address arithmetic
    assign top_idx   = count_reg - CW'(1);
    assign mid_idx   = count_reg >> 1;
    assign shift_idx = ptr_reg - CW'(2);

    always_comb
    begin
        unique case (cmd.rd_sel)
            swma_pkg::RD_TOP: rd_idx = top_idx;
            swma_pkg::RD_MID: rd_idx = mid_idx;
            swma_pkg::RD_PTR: rd_idx = ptr_reg;
            default:          rd_idx = ptr_reg;
        endcase
    end

    // write port: push at the top, or a shift step one place down
    assign wr_en   = cmd.wr_push | cmd.wr_shift;
    assign wr_addr = cmd.wr_push ? count_reg[AW-1:0] : shift_idx[AW-1:0];
    assign wr_data = cmd.wr_push ? push_value : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    // element count and shift pointer
    always_comb
    begin
        count_next = count_reg;
        if (cmd.wr_push)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CW'(1);
        end
        ptr_next = ptr_reg;
        if (cmd.ptr_load)
        begin
            ptr_next = mid_idx + CW'(1);
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
    end

    // result register
    always_comb
    begin
        value_next = value_reg;
        if (cmd.val_cap)
        begin
            value_next = rdata_reg;
        end
        if (cmd.out_load)
        begin
            unique case (cmd.val_sel)
                swma_pkg::VAL_ZERO:  value_next = '0;
                swma_pkg::VAL_RDATA: value_next = rdata_reg;
                swma_pkg::VAL_KEEP:  value_next = value_reg;
                default:             value_next = '0;
            endcase
        end
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        if (cmd.out_load)
        begin
            status_reg <= cmd.out_status;
            depth_reg  <= swma_pkg::DNOW_W'(count_next);
        end
    end

    // status back to the controller
    assign stat.full     = (count_reg == CW'(DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.ptr_done = (ptr_reg == count_reg);
    assign stat.out_busy = out_valid_reg & ~out_ready;

    assign out_valid    = out_valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;
    assign depth_now    = depth_reg;

endmodule

// ----- rtl/swma_ctrl.sv -----
// ----------------------------------------------------------------------------
// swma_ctrl
// operation sequencer of the stack with middle access block
// ----------------------------------------------------------------------------
module swma_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  swma_pkg::op_t     op,
    output logic              in_ready,
    input  swma_pkg::stat_t   stat,
    output swma_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_DMID  = 4'b0100,
        S_SHIFT = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    // take an item only when idle and the result slot frees up
    assign in_ready = (state_reg == S_IDLE) & ~stat.out_busy;
    assign accept   = in_valid & in_ready;

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.rd_sel     = swma_pkg::RD_TOP;
        cmd.out_status = swma_pkg::ST_OK;
        cmd.val_sel    = swma_pkg::VAL_ZERO;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op == swma_pkg::OP_PUSH)
                    begin
                        cmd.out_load = 1'b1;
                        if (stat.full)
                        begin
                            cmd.out_status = swma_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_push = 1'b1;
                        end
                    end
                    else if (stat.empty)
                    begin
                        cmd.out_load   = 1'b1;
                        cmd.out_status = swma_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        unique case (op)
                            swma_pkg::OP_POP:
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_sel  = swma_pkg::RD_TOP;
                                cmd.cnt_dec = 1'b1;
                                state_next  = S_READ;
                            end
                            swma_pkg::OP_MID:
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = swma_pkg::RD_MID;
                                state_next = S_READ;
                            end
                            swma_pkg::OP_DEL:
                            begin
                                cmd.rd_en    = 1'b1;
                                cmd.rd_sel   = swma_pkg::RD_MID;
                                cmd.ptr_load = 1'b1;
                                state_next   = S_DMID;
                            end
                            default:
                            begin
                                state_next = S_IDLE;
                            end
                        endcase
                    end
                end
            end
            S_READ:
            begin
                cmd.out_load = 1'b1;
                cmd.val_sel  = swma_pkg::VAL_RDATA;
                state_next   = S_IDLE;
            end
            S_DMID:
            begin
                // middle word arrives; start moving the upper part down
                cmd.val_cap = 1'b1;
                if (stat.ptr_done)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.val_sel  = swma_pkg::VAL_RDATA;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = swma_pkg::RD_PTR;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // write the word read last cycle, read the next one
                cmd.wr_shift = 1'b1;
                if (stat.ptr_done)
                begin
                    cmd.cnt_dec  = 1'b1;
                    cmd.out_load = 1'b1;
                    cmd.val_sel  = swma_pkg::VAL_KEEP;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_sel  = swma_pkg::RD_PTR;
                    cmd.ptr_inc = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/stack_with_middle_access_top.sv -----
// ----------------------------------------------------------------------------
// stack_with_middle_access_top
// bounded stack of signed words with read and delete of the middle element
// ----------------------------------------------------------------------------
// Usage: each item on the s_axis channel is one operation (tuser) with a push
// word (tdata). Each item gives exactly one result item on m_axis: the
// popped, middle or deleted word, a status code and the depth afterwards.
// The middle is the element at floor(depth/2) counted from the bottom.
// Push and any refused operation load the result at accept, so it is valid
// in the cycle after; pop and read middle go through the registered memory
// read and then the result register; delete middle reads the middle word,
// moves each word above it one place down with one memory read and one write
// per cycle, and loads the result as the last word is moved.
// One item is in work at a time; the next is taken in the cycle after the
// result is loaded, or the same cycle the previous result is taken.
// Reset clears the depth to zero and drops any pending result; memory words
// are not cleared. While m_axis_tready is low a result is held stable and
// s_axis_tready stays low until it is taken.
// ----------------------------------------------------------------------------
`include "stack_with_middle_access_top_assert.svh"

module stack_with_middle_access_top #(
    parameter int DEPTH = swma_pkg::DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] push_value
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] result_value, [36:32] depth_now
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    swma_pkg::cmd_t    cmd;
    swma_pkg::stat_t   stat;
    swma_pkg::status_t status;
    logic signed [swma_pkg::WORD_W-1:0] result_value;
    logic [swma_pkg::DNOW_W-1:0]        depth_now;
    swma_pkg::op_t     op;

    assign op = swma_pkg::op_t'(s_axis_tuser);

    // sequencer
    swma_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .op       (op),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage and result register
    swma_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .push_value   (s_axis_tdata),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .result_value (result_value),
        .status       (status),
        .depth_now    (depth_now)
    );

    // output packing
    assign m_axis_tdata = {3'b000, depth_now, result_value};
    assign m_axis_tuser = status;

    // checks
    `SWMA_ASSERT_NOW(a_no_accept_over_result,
        s_axis_tvalid && s_axis_tready, !(m_axis_tvalid && !m_axis_tready),
        "item accepted while a result is stalled")
    `SWMA_ASSERT_NEXT(a_empty_reply,
        s_axis_tvalid && s_axis_tready && stat.empty && (op != swma_pkg::OP_PUSH),
        m_axis_tvalid && (m_axis_tuser == swma_pkg::ST_EMPTY),
        "operation on empty stack not answered with empty status")
    `SWMA_ASSERT_NEXT(a_push_ok_reply,
        s_axis_tvalid && s_axis_tready && !stat.full && (op == swma_pkg::OP_PUSH),
        m_axis_tvalid && (m_axis_tuser == swma_pkg::ST_OK) && (result_value == 0),
        "accepted push not answered with ok status and zero word")
    `SWMA_ASSERT_NOW(a_single_write,
        1'b1, !(cmd.wr_push && cmd.wr_shift),
        "push and shift write in the same cycle")

endmodule

// ----- sim/stack_with_middle_access_top_tb.sv -----
// ----------------------------------------------------------------------------
// stack_with_middle_access_top_tb
// self-checking bench for the stack with middle access block
// ----------------------------------------------------------------------------
// Items are queued up front: a directed opening covers the empty and full
// corners and the short-stack deletes, then random operation mixes drift the
// depth between empty and full. A clocked driver sends them in bursts. An
// in-bench stack tracks every accepted item and queues the expected result.
// The receiver stalls on its own pattern; a clocked monitor checks each result,
// field by field, against the oldest expectation.
// ----------------------------------------------------------------------------
module stack_with_middle_access_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STACK_DEPTH  = swma_pkg::DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1850;
    localparam int DRAIN_EVERY  = 400;
    localparam int TAIL_CYCLES  = 40;
    localparam int CYCLE_LIMIT  = 500000;

    // one operation waiting to be sent
    typedef struct {
        swma_pkg::op_t                op;
        logic [swma_pkg::WORD_W-1:0]  word;
        bit                           hold_for_drain;
    } stack_op_t;

    // one expected result
    typedef struct {
        logic [swma_pkg::WORD_W-1:0]  value;
        swma_pkg::status_t            status;
        logic [swma_pkg::DNOW_W-1:0]  depth;
    } stack_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [31:0]       s_axis_tdata = '0;
    logic [1:0]        s_axis_tuser = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [39:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    stack_op_t         op_queue[$];
    stack_result_t     exp_results[$];

    // shadow copy of the stack contents
    logic [swma_pkg::WORD_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned       shadow_count = 0;

    int                mismatch_count = 0;
    int                cycle_count = 0;

    stack_with_middle_access_top #(
        .DEPTH(STACK_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // apply one operation to the shadow stack and return its result
    function automatic stack_result_t stack_apply(swma_pkg::op_t op,
                                                  logic [swma_pkg::WORD_W-1:0] word);
        stack_result_t r;
        int unsigned   mid_idx;
        int unsigned   k;
        r.value  = '0;
        r.status = swma_pkg::ST_OK;
        if (op == swma_pkg::OP_PUSH)
        begin
            if (shadow_count >= STACK_DEPTH)
                r.status = swma_pkg::ST_FULL;
            else
            begin
                shadow_words[shadow_count] = word;
                shadow_count++;
            end
        end
        else if (shadow_count == 0)
            r.status = swma_pkg::ST_EMPTY;
        else if (op == swma_pkg::OP_POP)
        begin
            shadow_count--;
            r.value = shadow_words[shadow_count];
        end
        else
        begin
            mid_idx = shadow_count / 2;
            r.value = shadow_words[mid_idx];
            if (op == swma_pkg::OP_DEL)
            begin
                for (k = mid_idx; k + 1 < shadow_count; k++)
                    shadow_words[k] = shadow_words[k + 1];
                shadow_count--;
            end
        end
        r.depth = shadow_count[swma_pkg::DNOW_W-1:0];
        return r;
    endfunction

    // random word, leaning on the extremes now and then
    function automatic logic [swma_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(swma_pkg::op_t op, logic [swma_pkg::WORD_W-1:0] word,
                            bit hold);
        stack_op_t item;
        item.op             = op;
        item.word           = word;
        item.hold_for_drain = hold;
        op_queue.push_back(item);
    endtask

    task automatic flag_mismatch(string what, logic [swma_pkg::WORD_W-1:0] got,
                                 logic [swma_pkg::WORD_W-1:0] want);
        $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // stimulus, reset and end of run
    initial
    begin
        int            lean;
        int            lean_left;
        int            pick;
        swma_pkg::op_t op;

        // empty stack corners
        queue_op(swma_pkg::OP_POP, rand_word(), 1'b0);
        queue_op(swma_pkg::OP_MID, rand_word(), 1'b0);
        queue_op(swma_pkg::OP_DEL, rand_word(), 1'b0);
        // delete middle with two, then with one element
        queue_op(swma_pkg::OP_PUSH, 32'h8000_0000, 1'b0);
        queue_op(swma_pkg::OP_PUSH, 32'h7FFF_FFFF, 1'b0);
        queue_op(swma_pkg::OP_DEL, rand_word(), 1'b0);
        queue_op(swma_pkg::OP_DEL, rand_word(), 1'b0);
        // fill to the top, push once more, then read and delete at full depth
        for (int i = 0; i < STACK_DEPTH; i++)
            queue_op(swma_pkg::OP_PUSH,
                     (i % 2) ? 32'hFFFF_FFFF - i : 32'h0000_0000 + i, 1'b0);
        queue_op(swma_pkg::OP_PUSH, 32'hA5A5_A5A5, 1'b0);
        queue_op(swma_pkg::OP_MID, rand_word(), 1'b0);
        queue_op(swma_pkg::OP_DEL, rand_word(), 1'b0);

        // random mixes that lean toward filling, emptying or neither
        lean      = 2;
        lean_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (lean_left == 0)
            begin
                lean      = $urandom_range(0, 2);
                lean_left = $urandom_range(15, 80);
            end
            lean_left--;
            pick = $urandom_range(0, 99);
            case (lean)
                0:       op = (pick < 65) ? swma_pkg::OP_PUSH :
                              (pick < 75) ? swma_pkg::OP_POP :
                              (pick < 88) ? swma_pkg::OP_MID : swma_pkg::OP_DEL;
                1:       op = (pick < 25) ? swma_pkg::OP_PUSH :
                              (pick < 50) ? swma_pkg::OP_POP :
                              (pick < 65) ? swma_pkg::OP_MID : swma_pkg::OP_DEL;
                default: op = (pick < 40) ? swma_pkg::OP_PUSH :
                              (pick < 60) ? swma_pkg::OP_POP :
                              (pick < 80) ? swma_pkg::OP_MID : swma_pkg::OP_DEL;
            endcase
            queue_op(op, rand_word(), (n % DRAIN_EVERY) == 0);
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (op_queue.size() != 0 || s_axis_tvalid || exp_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && exp_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // driver: bursts of items with random gaps, optional drain before an item
    int        burst_left = 1;
    int        gap_left = 0;
    bit        took;
    stack_op_t next_op;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took = s_axis_tvalid && s_axis_tready;
            if (took)
                exp_results.push_back(stack_apply(swma_pkg::op_t'(s_axis_tuser),
                                                  s_axis_tdata));
            if (took || !s_axis_tvalid)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (op_queue.size() != 0 &&
                         !(op_queue[0].hold_for_drain && exp_results.size() != 0))
                begin
                    next_op = op_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_op.word;
                    s_axis_tuser  <= next_op.op;
                    if (burst_left <= 1)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                                 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern: a mode held for a random span
    int mode_left = 0;
    int stall_mode = 0;

    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
            mode_left  <= $urandom_range(30, 200);
        end
        else
            mode_left <= mode_left - 1;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: m_axis_tready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // monitor: check each result against the oldest expectation
    stack_result_t want_res;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (exp_results.size() == 0)
                flag_mismatch("unexpected result", m_axis_tdata[31:0], '0);
            else
            begin
                want_res = exp_results.pop_front();
                if (m_axis_tdata[31:0] !== want_res.value)
                    flag_mismatch("result_value", m_axis_tdata[31:0], want_res.value);
                if (m_axis_tuser !== want_res.status)
                    flag_mismatch("status", 32'(m_axis_tuser), 32'(want_res.status));
                if (m_axis_tdata[36:32] !== want_res.depth)
                    flag_mismatch("depth_now", 32'(m_axis_tdata[36:32]),
                                  32'(want_res.depth));
            end
        end
    end

endmodule
